FILE: design/lensdm_pkg.sv
// ----------------------------------------------------------------------------
// lensdm_pkg
// shared widths, register codes, types and rounding/saturation helpers for
// the lens distortion mapper
// ----------------------------------------------------------------------------
package lensdm_pkg;

  localparam int COORD_W    = 16;
  localparam int COEFF_W    = 20;
  localparam int CNT_W      = 3;
  localparam int ACC_W      = 32;
  localparam int PROD_W     = 64;
  localparam int SQR_W      = 2 * COORD_W;
  localparam int SQ_W       = SQR_W + 1;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 5;
  localparam int IDX_W      = APB_AW - 2;
  localparam int NUM_STAGES = 11;

  // fixed-point shifts
  localparam int unsigned SQ_SHIFT  = 8;
  localparam int unsigned RAD_FRAC  = 16;
  localparam int unsigned TAN_SHIFT = 20;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEFF_W-1:0] coeff_t;
  typedef logic signed [SQR_W-1:0]   sqr_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic        [SQ_W-1:0]    sq_t;

  localparam prod_t ONE_Q16  = prod_t'(1) <<< RAD_FRAC;
  localparam prod_t ACC_HI   = (prod_t'(1) <<< (ACC_W - 1)) - prod_t'(1);
  localparam prod_t ACC_LO   = -(prod_t'(1) <<< (ACC_W - 1));
  localparam prod_t COORD_HI = (prod_t'(1) <<< (COORD_W - 1)) - prod_t'(1);
  localparam prod_t COORD_LO = -(prod_t'(1) <<< (COORD_W - 1));

  // register map, index = byte address / 4
  typedef enum logic [IDX_W-1:0] {
    REG_COUNT = 3'd0,
    REG_K1    = 3'd1,
    REG_K2    = 3'd2,
    REG_P1    = 3'd3,
    REG_P2    = 3'd4,
    REG_K3    = 3'd5
  } reg_idx_t;

  // coefficients as the datapath sees them, unused ones already zeroed
  typedef struct packed {
    logic   pass;
    coeff_t k1;
    coeff_t k2;
    coeff_t p1;
    coeff_t p2;
    coeff_t k3;
  } coeff_set_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctl_t;

  typedef struct packed {
    acc_t val;
    logic hit;
  } acc_sat_t;

  typedef struct packed {
    coord_t val;
    logic   hit;
  } coord_sat_t;

  // round to nearest, ties away from zero: floor((p + half - sign) / 2^sh)
  function automatic prod_t rnd_shr(input prod_t p, input int unsigned sh);
    prod_t bias;
    prod_t s;
    bias = (prod_t'(1) <<< (sh - 1)) - $signed({{(PROD_W-1){1'b0}}, p[PROD_W-1]});
    s    = p + bias;
    return s >>> sh;
  endfunction

  function automatic acc_sat_t sat_acc(input prod_t v);
    acc_sat_t r;
    if (v > ACC_HI) begin
      r.val = ACC_HI[ACC_W-1:0];
      r.hit = 1'b1;
    end else if (v < ACC_LO) begin
      r.val = ACC_LO[ACC_W-1:0];
      r.hit = 1'b1;
    end else begin
      r.val = v[ACC_W-1:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

  function automatic coord_sat_t sat_coord(input prod_t v);
    coord_sat_t r;
    if (v > COORD_HI) begin
      r.val = COORD_HI[COORD_W-1:0];
      r.hit = 1'b1;
    end else if (v < COORD_LO) begin
      r.val = COORD_LO[COORD_W-1:0];
      r.hit = 1'b1;
    end else begin
      r.val = v[COORD_W-1:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

  // rounded, saturated scaling of a registered product
  function automatic acc_sat_t rmul(input prod_t p, input int unsigned sh);
    return sat_acc(rnd_shr(p, sh));
  endfunction

endpackage

FILE: design/lensdm_regs.sv
// ----------------------------------------------------------------------------
// lensdm_regs
// apb register file for coefficient count and the five coefficients
// ----------------------------------------------------------------------------
module lensdm_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lensdm_pkg::APB_AW-1:0]  paddr,
  input  logic [lensdm_pkg::APB_DW-1:0]  pwdata,
  output logic [lensdm_pkg::APB_DW-1:0]  prdata,
  output logic                           pready,
  output lensdm_pkg::coeff_set_t         coeffs
);
  import lensdm_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MIN_ACTIVE = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_USE_P1     = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_USE_P2     = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_USE_K3     = CNT_W'(5);

  logic [CNT_W-1:0]   cnt_r;
  logic [COEFF_W-1:0] k1_r;
  logic [COEFF_W-1:0] k2_r;
  logic [COEFF_W-1:0] p1_r;
  logic [COEFF_W-1:0] p2_r;
  logic [COEFF_W-1:0] k3_r;
  logic [IDX_W-1:0]   idx;
  logic               wr_en;

  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      k1_r  <= '0;
      k2_r  <= '0;
      p1_r  <= '0;
      p2_r  <= '0;
      k3_r  <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_COUNT: cnt_r <= pwdata[CNT_W-1:0];
        REG_K1:    k1_r  <= pwdata[COEFF_W-1:0];
        REG_K2:    k2_r  <= pwdata[COEFF_W-1:0];
        REG_P1:    p1_r  <= pwdata[COEFF_W-1:0];
        REG_P2:    p2_r  <= pwdata[COEFF_W-1:0];
        REG_K3:    k3_r  <= pwdata[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COUNT: prdata = APB_DW'(cnt_r);
      REG_K1:    prdata = APB_DW'(k1_r);
      REG_K2:    prdata = APB_DW'(k2_r);
      REG_P1:    prdata = APB_DW'(p1_r);
      REG_P2:    prdata = APB_DW'(p2_r);
      REG_K3:    prdata = APB_DW'(k3_r);
      default:   prdata = '0;
    endcase
  end

  // p1, p2 and k3 beyond the count read as zero; a count below two selects pass-through
  always_comb begin
    coeffs.pass = (cnt_r < CNT_MIN_ACTIVE);
    coeffs.k1   = k1_r;
    coeffs.k2   = k2_r;
    coeffs.p1   = (cnt_r >= CNT_USE_P1) ? coeff_t'(p1_r) : '0;
    coeffs.p2   = (cnt_r >= CNT_USE_P2) ? coeff_t'(p2_r) : '0;
    coeffs.k3   = (cnt_r >= CNT_USE_K3) ? coeff_t'(k3_r) : '0;
  end

endmodule

FILE: design/lensdm_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// lensdm_pipe_ctrl
// per-stage valid bits with bubble collapsing; a stage loads when it is
// empty or when the stage after it moves
// ----------------------------------------------------------------------------
module lensdm_pipe_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lensdm_pkg::pipe_ctl_t  ctl
);
  import lensdm_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] adv;
  logic [NUM_STAGES-1:0] src_vld;

  assign src_vld = {vld_r[NUM_STAGES-2:0], in_valid};

  always_comb begin
    adv[NUM_STAGES-1] = ~vld_r[NUM_STAGES-1] | out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = ~vld_r[i] | adv[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      vld_nxt[i] = adv[i] ? src_vld[i] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.ld    = adv & src_vld;
  assign ctl.vld   = vld_r;
  assign in_ready  = adv[0];
  assign out_valid = vld_r[NUM_STAGES-1];

endmodule

FILE: design/lensdm_datapath.sv
// ----------------------------------------------------------------------------
// lensdm_datapath
// eleven-stage fixed-point datapath: squares, radial powers, radial factor,
// tangential terms, scaling and final saturation
// ----------------------------------------------------------------------------
module lensdm_datapath (
  input  logic                    clk,
  input  lensdm_pkg::pipe_ctl_t   ctl,
  input  lensdm_pkg::coeff_set_t  coeffs,
  input  lensdm_pkg::coord_t      x_in,
  input  lensdm_pkg::coord_t      y_in,
  output lensdm_pkg::coord_t      x_out,
  output lensdm_pkg::coord_t      y_out,
  output logic                    clipped
);
  import lensdm_pkg::*;

  // stage 0: input squares
  coord_t x0_r, y0_r;
  sqr_t   xxp0_r, yyp0_r, xyp0_r;
  // stage 1: r2 and scaled squares
  coord_t x1_r, y1_r;
  acc_t   r2_1_r, xx1_r, yy1_r, xy1_r;
  logic   sat1_r;
  // stage 2: first products and tangential operands
  coord_t x2_r, y2_r;
  acc_t   r2_2_r, xy2_2_r, sx2_r, sy2_r;
  prod_t  r4p2_r, k1r2p2_r;
  logic   sat2_r;
  // stage 3
  coord_t x3_r, y3_r;
  acc_t   r2_3_r, r4_3_r, a1_3_r;
  prod_t  tp1x3_r, tp2x3_r, tp1y3_r, tp2y3_r;
  logic   sat3_r;
  // stage 4
  coord_t x4_r, y4_r;
  acc_t   a1_4_r, tx4_r, ty4_r;
  prod_t  r6p4_r, k2r4p4_r;
  logic   sat4_r;
  // stage 5
  coord_t x5_r, y5_r;
  acc_t   a1_5_r, a2_5_r, r6_5_r, tx5_r, ty5_r;
  logic   sat5_r;
  // stage 6
  coord_t x6_r, y6_r;
  acc_t   a1_6_r, a2_6_r, tx6_r, ty6_r;
  prod_t  k3r6p6_r;
  logic   sat6_r;
  // stage 7: radial factor
  coord_t x7_r, y7_r;
  acc_t   rad7_r, tx7_r, ty7_r;
  logic   sat7_r;
  // stage 8
  coord_t x8_r, y8_r;
  prod_t  xrp8_r, yrp8_r;
  acc_t   tx8_r, ty8_r;
  logic   sat8_r;
  // stage 9
  coord_t x9_r, y9_r;
  acc_t   xr9_r, yr9_r, tx9_r, ty9_r;
  logic   sat9_r;
  // stage 10: output
  coord_t xo_r, yo_r;
  logic   clip_r;

  // next values
  sq_t        sq_nxt, r2f_nxt;
  acc_t       r2_1_nxt;
  logic       r2_hit;
  acc_sat_t   xx1_nxt, yy1_nxt, xy1_nxt;
  acc_sat_t   xy2_nxt, sx_nxt, sy_nxt;
  acc_sat_t   r4_nxt, a1_nxt;
  acc_sat_t   t1x, t2x, t1y, t2y, tx_nxt, ty_nxt;
  acc_sat_t   r6_nxt, a2_nxt;
  acc_sat_t   a3_nxt, rad_nxt;
  acc_sat_t   xr_nxt, yr_nxt;
  coord_sat_t xo_nxt, yo_nxt;

  // stage 1
  always_comb begin
    sq_nxt  = {1'b0, xxp0_r} + {1'b0, yyp0_r};
    r2f_nxt = (sq_nxt >> SQ_SHIFT) + SQ_W'(sq_nxt[SQ_SHIFT-1]);
    if (PROD_W'(r2f_nxt) > ACC_HI) begin
      r2_1_nxt = ACC_HI[ACC_W-1:0];
      r2_hit   = 1'b1;
    end else begin
      r2_1_nxt = r2f_nxt[ACC_W-1:0];
      r2_hit   = 1'b0;
    end
    xx1_nxt = rmul(PROD_W'(xxp0_r), SQ_SHIFT);
    yy1_nxt = rmul(PROD_W'(yyp0_r), SQ_SHIFT);
    xy1_nxt = rmul(PROD_W'(xyp0_r), SQ_SHIFT);
  end

  // stage 2
  always_comb begin
    xy2_nxt = sat_acc(PROD_W'(xy1_r) <<< 1);
    sx_nxt  = sat_acc(PROD_W'(r2_1_r) + (PROD_W'(xx1_r) <<< 1));
    sy_nxt  = sat_acc(PROD_W'(r2_1_r) + (PROD_W'(yy1_r) <<< 1));
  end

  // stage 3
  always_comb begin
    r4_nxt = rmul(r4p2_r, RAD_FRAC);
    a1_nxt = rmul(k1r2p2_r, RAD_FRAC);
  end

  // stage 4: tangential sums
  always_comb begin
    t1x    = rmul(tp1x3_r, TAN_SHIFT);
    t2x    = rmul(tp2x3_r, TAN_SHIFT);
    t1y    = rmul(tp1y3_r, TAN_SHIFT);
    t2y    = rmul(tp2y3_r, TAN_SHIFT);
    tx_nxt = sat_acc(PROD_W'(t1x.val) + PROD_W'(t2x.val));
    ty_nxt = sat_acc(PROD_W'(t1y.val) + PROD_W'(t2y.val));
  end

  // stage 5
  always_comb begin
    r6_nxt = rmul(r6p4_r, RAD_FRAC);
    a2_nxt = rmul(k2r4p4_r, RAD_FRAC);
  end

  // stage 7: radial factor
  always_comb begin
    a3_nxt  = rmul(k3r6p6_r, RAD_FRAC);
    rad_nxt = sat_acc(ONE_Q16 + PROD_W'(a1_6_r) + PROD_W'(a2_6_r) + PROD_W'(a3_nxt.val));
  end

  // stage 9
  always_comb begin
    xr_nxt = rmul(xrp8_r, RAD_FRAC);
    yr_nxt = rmul(yrp8_r, RAD_FRAC);
  end

  // stage 10
  always_comb begin
    xo_nxt = sat_coord(PROD_W'(xr9_r) + PROD_W'(tx9_r));
    yo_nxt = sat_coord(PROD_W'(yr9_r) + PROD_W'(ty9_r));
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[0]) begin
      x0_r   <= x_in;
      y0_r   <= y_in;
      xxp0_r <= SQR_W'(x_in) * SQR_W'(x_in);
      yyp0_r <= SQR_W'(y_in) * SQR_W'(y_in);
      xyp0_r <= SQR_W'(x_in) * SQR_W'(y_in);
    end
    if (ctl.ld[1]) begin
      x1_r   <= x0_r;
      y1_r   <= y0_r;
      r2_1_r <= r2_1_nxt;
      xx1_r  <= xx1_nxt.val;
      yy1_r  <= yy1_nxt.val;
      xy1_r  <= xy1_nxt.val;
      sat1_r <= r2_hit | xx1_nxt.hit | yy1_nxt.hit | xy1_nxt.hit;
    end
    if (ctl.ld[2]) begin
      x2_r     <= x1_r;
      y2_r     <= y1_r;
      r2_2_r   <= r2_1_r;
      xy2_2_r  <= xy2_nxt.val;
      sx2_r    <= sx_nxt.val;
      sy2_r    <= sy_nxt.val;
      r4p2_r   <= PROD_W'(r2_1_r) * PROD_W'(r2_1_r);
      k1r2p2_r <= PROD_W'(coeffs.k1) * PROD_W'(r2_1_r);
      sat2_r   <= sat1_r | xy2_nxt.hit | sx_nxt.hit | sy_nxt.hit;
    end
    if (ctl.ld[3]) begin
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      r2_3_r  <= r2_2_r;
      r4_3_r  <= r4_nxt.val;
      a1_3_r  <= a1_nxt.val;
      tp1x3_r <= PROD_W'(coeffs.p1) * PROD_W'(xy2_2_r);
      tp2x3_r <= PROD_W'(coeffs.p2) * PROD_W'(sx2_r);
      tp1y3_r <= PROD_W'(coeffs.p1) * PROD_W'(sy2_r);
      tp2y3_r <= PROD_W'(coeffs.p2) * PROD_W'(xy2_2_r);
      sat3_r  <= sat2_r | r4_nxt.hit | a1_nxt.hit;
    end
    if (ctl.ld[4]) begin
      x4_r     <= x3_r;
      y4_r     <= y3_r;
      a1_4_r   <= a1_3_r;
      tx4_r    <= tx_nxt.val;
      ty4_r    <= ty_nxt.val;
      r6p4_r   <= PROD_W'(r4_3_r) * PROD_W'(r2_3_r);
      k2r4p4_r <= PROD_W'(coeffs.k2) * PROD_W'(r4_3_r);
      sat4_r   <= sat3_r | t1x.hit | t2x.hit | t1y.hit | t2y.hit | tx_nxt.hit | ty_nxt.hit;
    end
    if (ctl.ld[5]) begin
      x5_r   <= x4_r;
      y5_r   <= y4_r;
      a1_5_r <= a1_4_r;
      a2_5_r <= a2_nxt.val;
      r6_5_r <= r6_nxt.val;
      tx5_r  <= tx4_r;
      ty5_r  <= ty4_r;
      sat5_r <= sat4_r | r6_nxt.hit | a2_nxt.hit;
    end
    if (ctl.ld[6]) begin
      x6_r     <= x5_r;
      y6_r     <= y5_r;
      a1_6_r   <= a1_5_r;
      a2_6_r   <= a2_5_r;
      k3r6p6_r <= PROD_W'(coeffs.k3) * PROD_W'(r6_5_r);
      tx6_r    <= tx5_r;
      ty6_r    <= ty5_r;
      sat6_r   <= sat5_r;
    end
    if (ctl.ld[7]) begin
      x7_r   <= x6_r;
      y7_r   <= y6_r;
      rad7_r <= rad_nxt.val;
      tx7_r  <= tx6_r;
      ty7_r  <= ty6_r;
      sat7_r <= sat6_r | a3_nxt.hit | rad_nxt.hit;
    end
    if (ctl.ld[8]) begin
      x8_r   <= x7_r;
      y8_r   <= y7_r;
      xrp8_r <= PROD_W'(x7_r) * PROD_W'(rad7_r);
      yrp8_r <= PROD_W'(y7_r) * PROD_W'(rad7_r);
      tx8_r  <= tx7_r;
      ty8_r  <= ty7_r;
      sat8_r <= sat7_r;
    end
    if (ctl.ld[9]) begin
      x9_r   <= x8_r;
      y9_r   <= y8_r;
      xr9_r  <= xr_nxt.val;
      yr9_r  <= yr_nxt.val;
      tx9_r  <= tx8_r;
      ty9_r  <= ty8_r;
      sat9_r <= sat8_r | xr_nxt.hit | yr_nxt.hit;
    end
    if (ctl.ld[10]) begin
      if (coeffs.pass) begin
        xo_r   <= x9_r;
        yo_r   <= y9_r;
        clip_r <= 1'b0;
      end else begin
        xo_r   <= xo_nxt.val;
        yo_r   <= yo_nxt.val;
        clip_r <= sat9_r | xo_nxt.hit | yo_nxt.hit;
      end
    end
  end

  assign x_out   = xo_r;
  assign y_out   = yo_r;
  assign clipped = clip_r;

endmodule

FILE: design/lens_distortion_mapper.sv
// ----------------------------------------------------------------------------
// lens_distortion_mapper
// brown-conrady lens distortion (k1, k2, k3 radial, p1, p2 tangential) on
// signed q3.12 normalized coordinates, q3.16 coefficients, saturating output
// ----------------------------------------------------------------------------
//
//   channel   | handshake                | payload
//   ----------+--------------------------+-----------------------------------
//   in        | in_valid / in_ready      | in_x_in, in_y_in (q3.12)
//   out       | out_valid / out_ready    | out_x_out, out_y_out, out_clipped
//   config    | psel/penable/pwrite/pready | paddr, pwdata, prdata (apb)
//
// - one beat per clock sustained while out_ready stays high; the pipeline
//   depth is set by the multiply / round-and-saturate stage pairs on the
//   r2 -> r4 -> r6 -> radial factor -> scaled coordinate chain
// - rst_n is synchronous; it empties the pipeline and clears the register file
// - a stall on out_ready holds the output register; empty stages further up
//   keep filling, so in_ready drops only when every stage is occupied
// - coefficient registers are read live by the stages, so they may only be
//   rewritten while the pipeline is empty
//
module lens_distortion_mapper (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lensdm_pkg::coord_t             in_x_in,
  input  lensdm_pkg::coord_t             in_y_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output lensdm_pkg::coord_t             out_x_out,
  output lensdm_pkg::coord_t             out_y_out,
  output logic                           out_clipped,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lensdm_pkg::APB_AW-1:0]  paddr,
  input  logic [lensdm_pkg::APB_DW-1:0]  pwdata,
  output logic [lensdm_pkg::APB_DW-1:0]  prdata,
  output logic                           pready
);
  import lensdm_pkg::*;

  coeff_set_t coeffs;
  pipe_ctl_t  ctl;

  // register file; p1, p2 and k3 past the programmed count come out as zero
  lensdm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coeffs  (coeffs)
  );

  // valid bits and per-stage load enables
  lensdm_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // arithmetic; the last stage is the output register
  lensdm_datapath u_dp (
    .clk     (clk),
    .ctl     (ctl),
    .coeffs  (coeffs),
    .x_in    (in_x_in),
    .y_in    (in_y_in),
    .x_out   (out_x_out),
    .y_out   (out_y_out),
    .clipped (out_clipped)
  );

  // an empty output register means nothing can be blocking the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output stage");

  // a beat in the last internal stage reaches the output when it can move
  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.vld[NUM_STAGES-2] && (out_ready || !out_valid)) |=> out_valid)
    else $error("beat lost between last stage and output register");

  // pass-through never reports saturation
  a_pass_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && coeffs.pass) |-> !out_clipped)
    else $error("clipped set in pass-through mode");

endmodule
